/* rtl/led_frame_serializer_top_defines.svh */
// assertion macros for the led frame serializer
`ifndef LED_FRAME_SERIALIZER_TOP_DEFINES_SVH
`define LED_FRAME_SERIALIZER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lfs_pkg.sv */
// shared types and constants for the led frame serializer
package lfs_pkg;

    localparam int CHANNELS_DEF   = 64;
    localparam int ROW_STRIDE_DEF = 8;
    localparam int ROW_COUNT_DEF  = 8;

    localparam int WORD_BITS = 12;
    localparam int BITPOS_W  = 4;
    localparam int COUNT_W   = 7;
    localparam int IDX_W     = 10;   // widest store index at the largest depth
    localparam int QDEPTH    = 2;

    typedef enum logic [1:0] {
        REQ_SET   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_TICK  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SHIFT = 2'd1,
        PH_LATCH = 2'd2
    } phase_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

    typedef struct packed {
        req_t                   op;
        logic                   in_range;
        logic [IDX_W-1:0]       idx;
        logic [WORD_BITS-1:0]   value;
        logic [COUNT_W-1:0]     count;
    } cmd_t;

    typedef struct packed {
        logic pop;
        logic init_sweep;
    } back_ctl_t;

endpackage

/* rtl/lfs_front.sv */
// front end: request decode and a short command queue
module lfs_front
    import lfs_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int ROW_STRIDE = ROW_STRIDE_DEF,
    parameter int ROW_COUNT  = ROW_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           req_type,
    input  logic [3:0]           col_x,
    input  logic [3:0]           row_y,
    input  logic [WORD_BITS-1:0] brightness,
    input  logic [COUNT_W-1:0]   word_count,
    input  back_ctl_t            back_ctl,
    output logic                 q_valid,
    output cmd_t                 q_cmd
);

    localparam int IDXS_W = IDX_W + 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    logic signed [IDXS_W-1:0] idx_s;
    cmd_t                     cmd;
    logic                     push;

    cmd_t               queue_mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    // signed store index, may fall below zero
    assign idx_s = IDXS_W'($signed({1'b0, col_x}) * ROW_STRIDE + ROW_COUNT
                           - $signed({1'b0, row_y}));

    always_comb
    begin
        cmd.op       = req_t'(req_type);
        cmd.in_range = (idx_s >= 0) && (idx_s < CHANNELS);
        cmd.idx      = idx_s[IDX_W-1:0];
        cmd.value    = brightness;
        if (int'(word_count) > CHANNELS)
        begin
            cmd.count = COUNT_W'(CHANNELS);
        end
        else
        begin
            cmd.count = word_count;
        end
    end

    assign in_ready = (count_reg < QCNT_W'(QDEPTH)) && !back_ctl.init_sweep;
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (back_ctl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !back_ctl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && back_ctl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= cmd;
        end
    end

endmodule

/* rtl/lfs_back.sv */
// back end: channel store, clear sweep, flush sequencer and result register
module lfs_back
    import lfs_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output back_ctl_t  back_ctl,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       serial_data,
    output logic       shift_clock_pulse,
    output logic       latch_blank_pulse,
    output logic       busy_res,
    output logic [1:0] status
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [WORD_BITS-1:0] store_mem [CHANNELS];
    logic [WORD_BITS-1:0] rd_word_reg;

    phase_t               phase_reg, phase_next;
    logic [COUNT_W-1:0]   wp_reg, wp_next;
    logic [BITPOS_W-1:0]  bp_reg, bp_next;
    logic [COUNT_W-1:0]   wts_reg, wts_next;

    logic                 sweep_reg, sweep_next;
    logic                 init_reg, init_next;
    logic [AW-1:0]        sweep_ptr_reg, sweep_ptr_next;
    logic [WORD_BITS-1:0] sweep_val_reg, sweep_val_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 data_reg, data_next;
    logic                 clk_pulse_reg, clk_pulse_next;
    logic                 latch_reg, latch_next;
    logic                 busy_reg, busy_next;
    logic [1:0]           status_reg, status_next;

    logic                 issue;
    logic                 busy_now;
    logic                 reject;
    logic                 do_flush;
    logic                 do_shift;
    logic                 do_latch;
    logic                 last_bit;
    logic                 last_word;
    logic [BITPOS_W-1:0]  bit_sel;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;

    assign issue     = q_valid && !sweep_reg && (!out_valid_reg || out_ready);
    assign busy_now  = (phase_reg != PH_IDLE);
    assign reject    = issue && (q_cmd.op != REQ_TICK) && busy_now;
    assign do_flush  = issue && (q_cmd.op == REQ_FLUSH) && !busy_now;
    assign do_shift  = issue && (q_cmd.op == REQ_TICK) && (phase_reg == PH_SHIFT);
    assign do_latch  = issue && (q_cmd.op == REQ_TICK) && (phase_reg == PH_LATCH);
    assign last_bit  = (bp_reg == BITPOS_W'(WORD_BITS - 1));
    assign last_word = ((wp_reg + 1'b1) >= wts_reg);
    assign bit_sel   = BITPOS_W'(WORD_BITS - 1) - bp_reg;

    assign back_ctl.pop        = issue;
    assign back_ctl.init_sweep = init_reg;

    // flush phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (do_flush)
                begin
                    phase_next = (q_cmd.count != '0) ? PH_SHIFT : PH_LATCH;
                end
            end
            PH_SHIFT:
            begin
                if (do_shift && last_bit && last_word)
                begin
                    phase_next = PH_LATCH;
                end
            end
            PH_LATCH:
            begin
                if (do_latch)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // datapath, store writes and result fields
    always_comb
    begin
        wp_next        = wp_reg;
        bp_next        = bp_reg;
        wts_next       = wts_reg;
        sweep_next     = sweep_reg;
        init_next      = init_reg;
        sweep_ptr_next = sweep_ptr_reg;
        sweep_val_next = sweep_val_reg;
        mem_we         = 1'b0;
        mem_addr       = sweep_ptr_reg;
        mem_wdata      = sweep_val_reg;

        data_next      = data_reg;
        clk_pulse_next = clk_pulse_reg;
        latch_next     = latch_reg;
        busy_next      = busy_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (sweep_reg)
        begin
            mem_we = 1'b1;
            if (sweep_ptr_reg == AW'(CHANNELS - 1))
            begin
                sweep_next     = 1'b0;
                init_next      = 1'b0;
                sweep_ptr_next = '0;
            end
            else
            begin
                sweep_ptr_next = sweep_ptr_reg + 1'b1;
            end
        end

        if (issue)
        begin
            out_valid_next = 1'b1;
            data_next      = 1'b0;
            clk_pulse_next = 1'b0;
            latch_next     = 1'b0;
            busy_next      = 1'b0;
            status_next    = ST_OK;
            if (reject)
            begin
                busy_next   = 1'b1;
                status_next = ST_BUSY;
            end
            else
            begin
                unique case (q_cmd.op)
                    REQ_SET:
                    begin
                        if (q_cmd.in_range)
                        begin
                            mem_we    = 1'b1;
                            mem_addr  = AW'(q_cmd.idx);
                            mem_wdata = q_cmd.value;
                        end
                        else
                        begin
                            status_next = ST_RANGE;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        sweep_next     = 1'b1;
                        sweep_ptr_next = '0;
                        sweep_val_next = q_cmd.value;
                    end
                    REQ_FLUSH:
                    begin
                        wts_next  = q_cmd.count;
                        wp_next   = '0;
                        bp_next   = '0;
                        busy_next = 1'b1;
                    end
                    REQ_TICK:
                    begin
                        if (do_shift)
                        begin
                            data_next      = rd_word_reg[bit_sel];
                            clk_pulse_next = 1'b1;
                            busy_next      = 1'b1;
                            if (last_bit)
                            begin
                                bp_next = '0;
                                wp_next = wp_reg + 1'b1;
                            end
                            else
                            begin
                                bp_next = bp_reg + 1'b1;
                            end
                        end
                        else if (do_latch)
                        begin
                            latch_next = 1'b1;
                            wp_next    = '0;
                            bp_next    = '0;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            wp_reg        <= '0;
            bp_reg        <= '0;
            wts_reg       <= '0;
            sweep_reg     <= 1'b1;
            init_reg      <= 1'b1;
            sweep_ptr_reg <= '0;
            sweep_val_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            wp_reg        <= wp_next;
            bp_reg        <= bp_next;
            wts_reg       <= wts_next;
            sweep_reg     <= sweep_next;
            init_reg      <= init_next;
            sweep_ptr_reg <= sweep_ptr_next;
            sweep_val_reg <= sweep_val_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg      <= data_next;
        clk_pulse_reg <= clk_pulse_next;
        latch_reg     <= latch_next;
        busy_reg      <= busy_next;
        status_reg    <= status_next;
    end

    // store: one write port, registered read that follows the word pointer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= mem_wdata;
        end
        rd_word_reg <= store_mem[AW'(wp_next)];
    end

    assign out_valid         = out_valid_reg;
    assign serial_data       = data_reg;
    assign shift_clock_pulse = clk_pulse_reg;
    assign latch_blank_pulse = latch_reg;
    assign busy_res          = busy_reg;
    assign status            = status_reg;

endmodule

/* rtl/led_frame_serializer_top.sv */
// top level of the led frame serializer
//
// channel   dir  handshake            payload
// request   in   in_valid / in_ready  req_type col_x row_y brightness word_count
// result    out  out_valid / out_ready serial_data shift_clock_pulse
//                                     latch_blank_pulse busy_res status
//
// one result per request; ticks stream at one bit per cycle while results drain
// a clear request writes the store one word a cycle while later requests wait
// in the queue
// after reset the same sweep zeroes the store, with in_ready low throughout
// a stalled result register stops the back end; the two-entry queue keeps
// taking requests meanwhile until it is full
module led_frame_serializer_top
    import lfs_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int ROW_STRIDE = ROW_STRIDE_DEF,
    parameter int ROW_COUNT  = ROW_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           req_type,
    input  logic [3:0]           col_x,
    input  logic [3:0]           row_y,
    input  logic [WORD_BITS-1:0] brightness,
    input  logic [COUNT_W-1:0]   word_count,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 serial_data,
    output logic                 shift_clock_pulse,
    output logic                 latch_blank_pulse,
    output logic                 busy_res,
    output logic [1:0]           status
);

`include "led_frame_serializer_top_defines.svh"

    // decoded requests waiting for the back end
    logic      q_valid;
    cmd_t      q_cmd;
    back_ctl_t back_ctl;

    // front: index math, count saturation, queue
    lfs_front #(
        .CHANNELS   (CHANNELS),
        .ROW_STRIDE (ROW_STRIDE),
        .ROW_COUNT  (ROW_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .col_x      (col_x),
        .row_y      (row_y),
        .brightness (brightness),
        .word_count (word_count),
        .back_ctl   (back_ctl),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd)
    );

    // back: store, flush sequencer, result register
    lfs_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_cmd             (q_cmd),
        .back_ctl          (back_ctl),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .serial_data       (serial_data),
        .shift_clock_pulse (shift_clock_pulse),
        .latch_blank_pulse (latch_blank_pulse),
        .busy_res          (busy_res),
        .status            (status)
    );

    // the back end never takes from an empty queue
    `LFS_ASSERT_NOW(a_pop_needs_entry, back_ctl.pop, q_valid, "pop from empty queue")

    // no request enters while the store is still being zeroed
    `LFS_ASSERT_NOW(a_init_blocks_input, back_ctl.init_sweep, !in_ready, "request during init")

    // a result taken with no new command behind it leaves the output empty
    `LFS_ASSERT_NEXT(a_out_drains, out_valid && out_ready && !back_ctl.pop, !out_valid,
        "result repeated")

    // data bits only travel with a shift clock, never with the latch pulse
    `LFS_ASSERT_NOW(a_pulse_exclusive, out_valid && (serial_data || latch_blank_pulse),
        !(shift_clock_pulse && latch_blank_pulse) && (!serial_data || shift_clock_pulse),
        "bad pulse combination")

endmodule

/* dv/tb_top.sv */
// self-checking testbench for the led frame serializer top level
module tb_top
    import lfs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // geometry of the default build
    localparam int CHANNELS   = CHANNELS_DEF;
    localparam int ROW_STRIDE = ROW_STRIDE_DEF;
    localparam int ROW_COUNT  = ROW_COUNT_DEF;

    // accepted requests, directed table included, after which the random part stops
    localparam int TOTAL_ITEMS  = 800;
    // accepted requests, directed table included, to pass before the full-store flush
    localparam int BULK_START   = 60;
    // watchdog limit on the run length
    localparam int CYCLE_LIMIT  = 1_000_000;
    // cycles of quiet after the last result, to catch stray outputs
    localparam int TAIL_CYCLES  = 20;
    // mismatch lines printed before going quiet
    localparam int PRINT_LIMIT  = 40;

    // one request as it sits on the input ports
    typedef struct {
        req_t                 op;
        logic [3:0]           x;
        logic [3:0]           y;
        logic [WORD_BITS-1:0] level;
        logic [COUNT_W-1:0]   count;
    } led_req_t;

    // the pins of one result
    typedef struct packed {
        logic       data;
        logic       clock_pulse;
        logic       latch;
        logic       busy;
        logic [1:0] status;
    } led_pins_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        led_req_t  req;
        bit        typed;
        led_pins_t want;
    } stim_row_t;

    // results that can be read off directly
    localparam led_pins_t PINS_QUIET    = {4'b0000, ST_OK};
    localparam led_pins_t PINS_RANGE    = {4'b0000, ST_RANGE};
    localparam led_pins_t PINS_BUSY_ACK = {4'b0001, ST_OK};
    localparam led_pins_t PINS_REJECT   = {4'b0001, ST_BUSY};
    localparam led_pins_t PINS_LATCH    = {4'b0010, ST_OK};

    // ports of the block; the inputs are known from time zero
    logic                 clk               = 1'b0;
    logic                 rst_n             = 1'b0;
    logic                 in_valid          = 1'b0;
    logic                 in_ready;
    logic [1:0]           req_type          = 2'd0;
    logic [3:0]           col_x             = 4'd0;
    logic [3:0]           row_y             = 4'd0;
    logic [WORD_BITS-1:0] brightness        = '0;
    logic [COUNT_W-1:0]   word_count        = '0;
    logic                 out_valid;
    logic                 out_ready         = 1'b0;
    logic                 serial_data;
    logic                 shift_clock_pulse;
    logic                 latch_blank_pulse;
    logic                 busy_res;
    logic [1:0]           status;

    // shadow copy of the frame store and the shift engine
    logic [WORD_BITS-1:0] model_store [CHANNELS];
    phase_t               model_phase = PH_IDLE;
    int                   model_word  = 0;
    int                   model_bitpos = 0;
    int                   model_words = 0;

    // pin results still owed by the block, oldest first
    led_pins_t            expected_pins [$];
    stim_row_t            directed_rows [$];

    int  error_count   = 0;
    int  result_count  = 0;
    int  cycle_count   = 0;
    // every accepted request
    int  sent_reqs     = 0;
    // requests that changed something or were flagged out of range
    int  useful_reqs   = 0;
    // ticks spent in the full-store flush
    int  bulk_ticks    = 0;
    int  range_rejects = 0;
    int  busy_rejects  = 0;
    int  idle_ticks    = 0;
    int  shifted_bits  = 0;
    int  latch_count   = 0;
    int  clear_count   = 0;
    int  flush_count   = 0;
    // stretches with no gaps on either side
    bit  send_burst    = 1'b0;
    bit  sink_burst    = 1'b0;

    led_frame_serializer_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .req_type          (req_type),
        .col_x             (col_x),
        .row_y             (row_y),
        .brightness        (brightness),
        .word_count        (word_count),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .serial_data       (serial_data),
        .shift_clock_pulse (shift_clock_pulse),
        .latch_blank_pulse (latch_blank_pulse),
        .busy_res          (busy_res),
        .status            (status)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, expected_pins.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // gap length: mostly none or short, now and then long
    function automatic int idle_len(input bit burst);
        int roll;
        if (burst)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 20);
    endfunction

    // what the serializer does with one accepted request
    function automatic led_pins_t serializer_step(input led_req_t r);
        led_pins_t res;
        int        idx;
        int        wp;
        int        bp;
        int        cnt;
        res = '0;
        // anything but a tick bounces off a running flush
        if (r.op != REQ_TICK && model_phase != PH_IDLE)
        begin
            res.busy   = 1'b1;
            res.status = ST_BUSY;
            busy_rejects++;
            return res;
        end
        case (r.op)
            REQ_SET:
            begin
                useful_reqs++;
                // row index counts down from ROW_COUNT, so it can go negative
                idx = int'(r.x) * ROW_STRIDE + ROW_COUNT - int'(r.y);
                if (idx < 0 || idx >= CHANNELS)
                begin
                    res.status = ST_RANGE;
                    range_rejects++;
                end
                else
                    model_store[idx] = r.level;
            end
            REQ_CLEAR:
            begin
                useful_reqs++;
                clear_count++;
                for (int i = 0; i < CHANNELS; i++)
                    model_store[i] = r.level;
            end
            REQ_FLUSH:
            begin
                useful_reqs++;
                flush_count++;
                // oversized counts saturate to the store depth
                cnt = (int'(r.count) > CHANNELS) ? CHANNELS : int'(r.count);
                model_words  = cnt;
                model_word   = 0;
                model_bitpos = 0;
                model_phase  = (cnt != 0) ? PH_SHIFT : PH_LATCH;
                res.busy     = 1'b1;
            end
            default:
            begin
                if (model_phase == PH_SHIFT)
                begin
                    useful_reqs++;
                    shifted_bits++;
                    wp = (model_word >= CHANNELS) ? CHANNELS - 1 : model_word;
                    bp = (model_bitpos >= WORD_BITS) ? WORD_BITS - 1 : model_bitpos;
                    // msb goes out first
                    res.data        = model_store[wp][WORD_BITS-1-bp];
                    res.clock_pulse = 1'b1;
                    res.busy        = 1'b1;
                    bp++;
                    if (bp >= WORD_BITS)
                    begin
                        bp = 0;
                        wp++;
                        if (wp >= model_words)
                            model_phase = PH_LATCH;
                    end
                    model_word   = wp;
                    model_bitpos = bp;
                end
                else if (model_phase == PH_LATCH)
                begin
                    useful_reqs++;
                    latch_count++;
                    model_phase  = PH_IDLE;
                    model_word   = 0;
                    model_bitpos = 0;
                    res.latch    = 1'b1;
                end
                else
                    idle_ticks++;
            end
        endcase
        return res;
    endfunction

    // request with every field random; callers overwrite what matters
    function automatic led_req_t rand_req(input req_t op);
        led_req_t r;
        r.op    = op;
        r.x     = 4'($urandom_range(0, 15));
        r.y     = 4'($urandom_range(0, 15));
        r.level = WORD_BITS'($urandom_range(0, (1 << WORD_BITS) - 1));
        r.count = COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1));
        return r;
    endfunction

    // holds the request until accepted, then logs what the block owes
    task automatic send_request(input led_req_t r, input bit typed, input led_pins_t want);
        led_pins_t predicted;
        int        gap;
        in_valid   <= 1'b1;
        req_type   <= r.op;
        col_x      <= r.x;
        row_y      <= r.y;
        brightness <= r.level;
        word_count <= r.count;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        sent_reqs++;
        predicted = serializer_step(r);
        expected_pins.push_back(typed ? want : predicted);
        gap = idle_len(send_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending until every owed result is out
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_pins.size() != 0);
    endtask

    // tick until the model says the flush is done
    task automatic finish_frame(input bit bulk);
        while (model_phase != PH_IDLE)
        begin
            send_request(rand_req(REQ_TICK), 1'b0, PINS_QUIET);
            if (bulk)
                bulk_ticks++;
        end
    endtask

    // flush, then tick it out with an odd request thrown in now and then
    task automatic shift_frame(input logic [COUNT_W-1:0] cnt, input bit bulk);
        led_req_t r;
        r       = rand_req(REQ_FLUSH);
        r.count = cnt;
        send_request(r, 1'b0, PINS_QUIET);
        while (model_phase != PH_IDLE)
        begin
            if ($urandom_range(0, 19) == 0)
                send_request(rand_req(req_t'($urandom_range(0, 2))), 1'b0, PINS_QUIET);
            else
            begin
                send_request(rand_req(REQ_TICK), 1'b0, PINS_QUIET);
                if (bulk)
                    bulk_ticks++;
            end
        end
    endtask

    task automatic add_row(input req_t op, input int x, input int y, input int level,
                           input int cnt, input bit typed, input led_pins_t want);
        stim_row_t row;
        row.req.op    = op;
        row.req.x     = 4'(x);
        row.req.y     = 4'(y);
        row.req.level = WORD_BITS'(level);
        row.req.count = COUNT_W'(cnt);
        row.typed     = typed;
        row.want      = want;
        directed_rows.push_back(row);
    endtask

    // result sink: runs of ready with stalls between, some runs stall-free
    initial
    begin : result_sink
        int run;
        int stall;
        @(posedge clk);
        forever
        begin
            sink_burst = ($urandom_range(0, 3) == 0);
            run = sink_burst ? $urandom_range(20, 60) : $urandom_range(1, 12);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = idle_len(sink_burst);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // compare every accepted result against the oldest owed one
    always @(posedge clk)
    begin : pin_check
        led_pins_t want;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (expected_pins.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing owed",
                                          result_count));
            else
            begin
                want = expected_pins.pop_front();
                if (serial_data !== want.data)
                    report_mismatch($sformatf("result %0d serial_data %b, want %b",
                                              result_count, serial_data, want.data));
                if (shift_clock_pulse !== want.clock_pulse)
                    report_mismatch($sformatf("result %0d shift_clock_pulse %b, want %b",
                                              result_count, shift_clock_pulse,
                                              want.clock_pulse));
                if (latch_blank_pulse !== want.latch)
                    report_mismatch($sformatf("result %0d latch_blank_pulse %b, want %b",
                                              result_count, latch_blank_pulse, want.latch));
                if (busy_res !== want.busy)
                    report_mismatch($sformatf("result %0d busy_res %b, want %b",
                                              result_count, busy_res, want.busy));
                if (status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              result_count, status, want.status));
            end
            result_count++;
        end
    end

    // stimulus: directed table, then random sequences, then drain and verdict
    initial
    begin : stimulus
        led_req_t r;
        int       roll;
        bit       big_over_done;
        big_over_done = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
            model_store[i] = '0;

        // single reset at the start; the block then sweeps its store
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // tick on an idle block does nothing
        add_row(REQ_TICK,   0,  0, 12'h000, 0, 1'b1, PINS_QUIET);
        add_row(REQ_CLEAR,  3,  9, 12'hFFF, 0, 1'b1, PINS_QUIET);
        // first word of the store, then the three ways to miss it
        add_row(REQ_SET,    0,  8, 12'h5A3, 0, 1'b1, PINS_QUIET);
        add_row(REQ_SET,   15,  0, 12'h123, 0, 1'b1, PINS_RANGE);
        add_row(REQ_SET,    0, 15, 12'hFFF, 0, 1'b1, PINS_RANGE);
        add_row(REQ_SET,    7,  0, 12'h001, 0, 1'b1, PINS_RANGE);
        // last word of the store
        add_row(REQ_SET,    7,  1, 12'h000, 0, 1'b1, PINS_QUIET);
        // one-word flush, with set, clear and a second flush bouncing off it
        add_row(REQ_FLUSH, 15, 15, 12'hFFF, 1, 1'b1, PINS_BUSY_ACK);
        add_row(REQ_SET,    0,  8, 12'hFFF, 0, 1'b1, PINS_REJECT);
        add_row(REQ_CLEAR,  0,  0, 12'h000, 0, 1'b1, PINS_REJECT);
        add_row(REQ_FLUSH,  0,  0, 12'h000, 5, 1'b1, PINS_REJECT);
        // twelve data bits, then the latch tick
        repeat (WORD_BITS + 1)
            add_row(REQ_TICK, 0, 0, 12'h000, 0, 1'b0, PINS_QUIET);
        // empty flush goes straight to the latch
        add_row(REQ_FLUSH,  0,  0, 12'h000, 0, 1'b1, PINS_BUSY_ACK);
        add_row(REQ_TICK,   0,  0, 12'h000, 0, 1'b1, PINS_LATCH);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        // hold off until the block has caught up
        wait_for_drain();

        while (sent_reqs < TOTAL_ITEMS)
        begin
            send_burst = ($urandom_range(0, 4) == 0);
            // the whole store once, through count saturation
            if (!big_over_done && sent_reqs > BULK_START)
            begin
                finish_frame(1'b0);
                wait_for_drain();
                shift_frame({COUNT_W{1'b1}}, 1'b1);
                big_over_done = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 65)
            begin
                // well-formed frame: optional clear, some set points, maybe a short flush
                finish_frame(1'b0);
                if ($urandom_range(0, 9) == 0)
                    send_request(rand_req(REQ_CLEAR), 1'b0, PINS_QUIET);
                repeat ($urandom_range(1, 4))
                begin
                    r = rand_req(REQ_SET);
                    if ($urandom_range(0, 3) != 0)
                    begin
                        // lands inside the store
                        r.x = 4'($urandom_range(0, 7));
                        r.y = 4'($urandom_range(1, 8));
                    end
                    send_request(r, 1'b0, PINS_QUIET);
                end
                if ($urandom_range(0, 3) != 0)
                    shift_frame(COUNT_W'($urandom_range(0,
                                         ($urandom_range(0, 4) == 0) ? 8 : 3)),
                                1'b0);
            end
            else
            begin
                // noise: any request kind, flushes kept short
                repeat ($urandom_range(1, 4))
                begin
                    r = rand_req(req_t'($urandom_range(0, 3)));
                    if (r.op == REQ_FLUSH)
                        r.count = COUNT_W'($urandom_range(0, 6));
                    send_request(r, 1'b0, PINS_QUIET);
                end
            end
            if ($urandom_range(0, 29) == 0)
                wait_for_drain();
        end

        finish_frame(1'b0);
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_pins.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_pins.size()));

        $display("covered %0d requests (%0d did work, %0d ticks in the full-store flush)",
                 sent_reqs, useful_reqs, bulk_ticks);
        $display("%0d clears, %0d flushes, %0d bits, %0d latches, %0d range, %0d busy, %0d idle",
                 clear_count, flush_count, shifted_bits, latch_count,
                 range_rejects, busy_rejects, idle_ticks);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
